>>> rtl/core/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, masked while reset is held.
`define ITC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("itc assertion failed");

// Checked on every rising clock edge, reset included.
`define ITC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("itc assertion failed");

`endif

>>> rtl/core/itc_pkg.sv
package itc_pkg;

  // request word
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] port;
    logic [7:0] write_data;
  } itc_req_t;

  // response word
  typedef struct packed {
    logic [7:0] read_data;
    logic       out_level;
    logic       irq_rise;
  } itc_rsp_t;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic [1:0] PORT_DATA = 2'd0;
  localparam logic [1:0] PORT_CMD  = 2'd3;

  // command byte fields
  localparam logic [1:0] CHAN_ZERO    = 2'b00;
  localparam logic [1:0] ACCESS_LATCH = 2'b00;
  localparam logic [1:0] ACCESS_LOHI  = 2'b11;

  localparam int unsigned COUNT_W = 16;

endpackage

>>> rtl/core/itc_level.sv
// Square-wave level for a count within a period; zero stands for 65536 in both.
module itc_level
  import itc_pkg::*;
(
  input  logic [COUNT_W-1:0] count,
  input  logic [COUNT_W-1:0] period,
  output logic               level
);

  logic [COUNT_W:0] count_ext;
  logic [COUNT_W:0] period_ext;

  assign count_ext  = {(count == '0), count};
  assign period_ext = {(period == '0), period};
  assign level      = (count_ext > (period_ext >> 1));

endmodule

>>> rtl/core/interval_timer_channel.sv
// Channel zero of an interval timer, square-wave mode, binary count. Each request
// word is a bus write, a bus read or one timer tick, and each gives one response
// word. One word is taken every clock cycle while req_stall is low; a word is
// registered on entry, all its work is done in a single pass of logic against the
// timer state, and the response is then offered from an output register. Stall on
// the response side backs up into the request side once both registers are full.
module interval_timer_channel
  import itc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  itc_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output itc_rsp_t rsp
);

  // input register
  logic     req_full;
  itc_req_t req_q;
  logic     advance;

  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = req_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (!req_stall) begin
      req_full <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      req_q <= req;
    end
  end

  // timer state
  logic [COUNT_W-1:0] live_count,    live_count_next;
  logic [COUNT_W-1:0] reload_value,  reload_value_next;
  logic [COUNT_W-1:0] latched_count, latched_count_next;
  logic latch_held,      latch_held_next;
  logic write_high,      write_high_next;
  logic read_high,       read_high_next;
  logic counting,        counting_next;
  logic wave_level,      wave_level_next;
  itc_rsp_t rsp_next;

  logic               new_level;
  logic [COUNT_W-1:0] read_src;
  logic [1:0]         cmd_chan;
  logic [1:0]         cmd_access;

  itc_level u_level (
    .count  (live_count_next),
    .period (reload_value_next),
    .level  (new_level)
  );

  assign read_src   = latch_held ? latched_count : live_count;
  assign cmd_chan   = req_q.write_data[7:6];
  assign cmd_access = req_q.write_data[5:4];

  always_comb begin
    live_count_next    = live_count;
    reload_value_next  = reload_value;
    latched_count_next = latched_count;
    latch_held_next    = latch_held;
    write_high_next    = write_high;
    read_high_next     = read_high;
    counting_next      = counting;
    wave_level_next    = wave_level;
    rsp_next.read_data = '0;
    rsp_next.irq_rise  = 1'b0;

    unique case (req_q.kind)
      KIND_WRITE: begin
        if (req_q.port == PORT_CMD) begin
          if (cmd_chan == CHAN_ZERO) begin
            if (cmd_access == ACCESS_LATCH) begin
              if (!latch_held) begin
                latched_count_next = live_count;
                latch_held_next    = 1'b1;
              end
            end else if (cmd_access == ACCESS_LOHI) begin
              counting_next   = 1'b0;
              latch_held_next = 1'b0;
              write_high_next = 1'b0;
              read_high_next  = 1'b0;
              wave_level_next = 1'b1;
            end
          end
        end else if (req_q.port == PORT_DATA) begin
          if (!write_high) begin
            reload_value_next = {reload_value[15:8], req_q.write_data};
            write_high_next   = 1'b1;
          end else begin
            // high byte completes the divisor and restarts the count
            reload_value_next = {req_q.write_data, reload_value[7:0]};
            write_high_next   = 1'b0;
            live_count_next   = reload_value_next;
            counting_next     = 1'b1;
            wave_level_next   = new_level;
          end
        end
      end
      KIND_READ: begin
        if (req_q.port == PORT_DATA) begin
          if (!read_high) begin
            rsp_next.read_data = read_src[7:0];
            read_high_next     = 1'b1;
          end else begin
            rsp_next.read_data = read_src[15:8];
            read_high_next     = 1'b0;
            latch_held_next    = 1'b0;
          end
        end
      end
      KIND_TICK: begin
        if (counting) begin
          if (live_count == COUNT_W'(1)) begin
            live_count_next = reload_value;
          end else begin
            live_count_next = live_count - COUNT_W'(1);
          end
          wave_level_next   = new_level;
          rsp_next.irq_rise = !wave_level && new_level;
        end
      end
      default: begin
      end
    endcase

    rsp_next.out_level = wave_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count    <= '0;
      reload_value  <= '0;
      latched_count <= '0;
      latch_held    <= 1'b0;
      write_high    <= 1'b0;
      read_high     <= 1'b0;
      counting      <= 1'b0;
      wave_level    <= 1'b1;
      rsp_valid     <= 1'b0;
    end else if (advance) begin
      rsp_valid <= req_full;
      if (req_full) begin
        live_count    <= live_count_next;
        reload_value  <= reload_value_next;
        latched_count <= latched_count_next;
        latch_held    <= latch_held_next;
        write_high    <= write_high_next;
        read_high     <= read_high_next;
        counting      <= counting_next;
        wave_level    <= wave_level_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && req_full) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> rtl/core/itc_checker.sv
`include "assert_macros.svh"

module itc_checker
  import itc_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     rsp_valid,
  input logic     rsp_stall,
  input itc_rsp_t rsp
);

  // a held response word stays put
  `ITC_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))

  // an interrupt only on a rising edge, so the level must be high
  `ITC_ASSERT(a_irq_level, rsp_valid && rsp.irq_rise |-> rsp.out_level)

  // ticks never return read data
  `ITC_ASSERT(a_irq_no_data, rsp_valid && rsp.irq_rise |-> rsp.read_data == 8'd0)

  // nothing is offered straight after reset
  `ITC_ASSERT_ALWAYS(a_rst_empty, rst |=> !rsp_valid)

endmodule

bind interval_timer_channel itc_checker u_itc_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

>>> bench/interval_timer_channel_chk.sv
module interval_timer_channel_chk
  import itc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_stall,
  input  itc_req_t req,
  input  logic     rsp_valid,
  input  logic     rsp_stall,
  input  itc_rsp_t rsp,
  output int       errors,
  output int       owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // timer state as the channel should hold it
  logic [15:0] live_cnt;
  logic [15:0] reload_val;
  logic [15:0] latch_val;
  logic        latch_held;
  logic        wr_hi;
  logic        rd_hi;
  logic        running;
  logic        level;

  itc_rsp_t rsp_due[$];
  int       rsp_seen;

  initial begin
    errors = 0;
    owed = 0;
    rsp_seen = 0;
  end

  // high while the count is above half the period; zero stands for 65536
  function automatic logic level_at(logic [15:0] cnt, logic [15:0] per);
    logic [16:0] p;
    logic [16:0] e;
    p = (per == 16'd0) ? 17'h10000 : {1'b0, per};
    e = (cnt == 16'd0) ? 17'h10000 : {1'b0, cnt};
    return e > (p >> 1);
  endfunction

  task automatic timer_step(input itc_req_t w, output itc_rsp_t r);
    logic       was_high;
    logic [1:0] chan;
    logic [1:0] acc;
    logic [15:0] src;
    r = '0;
    chan = w.write_data[7:6];
    acc = w.write_data[5:4];
    case (w.kind)
      KIND_WRITE: begin
        if (w.port == PORT_CMD) begin
          if (chan == CHAN_ZERO) begin
            if (acc == ACCESS_LATCH) begin
              if (!latch_held) begin
                latch_val = live_cnt;
                latch_held = 1'b1;
              end
            end else if (acc == ACCESS_LOHI) begin
              running = 1'b0;
              latch_held = 1'b0;
              wr_hi = 1'b0;
              rd_hi = 1'b0;
              level = 1'b1;
            end
          end
        end else if (w.port == PORT_DATA) begin
          if (!wr_hi) begin
            reload_val[7:0] = w.write_data;
            wr_hi = 1'b1;
          end else begin
            reload_val[15:8] = w.write_data;
            wr_hi = 1'b0;
            live_cnt = reload_val;
            running = 1'b1;
            level = level_at(live_cnt, reload_val);
          end
        end
      end
      KIND_READ: begin
        if (w.port == PORT_DATA) begin
          src = latch_held ? latch_val : live_cnt;
          if (!rd_hi) begin
            r.read_data = src[7:0];
            rd_hi = 1'b1;
          end else begin
            r.read_data = src[15:8];
            rd_hi = 1'b0;
            latch_held = 1'b0;
          end
        end
      end
      KIND_TICK: begin
        if (running) begin
          was_high = level;
          if (live_cnt == 16'd1) live_cnt = reload_val;
          else live_cnt = live_cnt - 16'd1;
          level = level_at(live_cnt, reload_val);
          r.irq_rise = !was_high && level;
        end
      end
      default: ;
    endcase
    r.out_level = level;
  endtask

  always @(posedge clk) begin
    itc_rsp_t want;
    if (rst) begin
      live_cnt = '0;
      reload_val = '0;
      latch_val = '0;
      latch_held = 1'b0;
      wr_hi = 1'b0;
      rd_hi = 1'b0;
      running = 1'b0;
      level = 1'b1;
      rsp_due.delete();
    end else begin
      if (req_valid && !req_stall) begin
        timer_step(req, want);
        rsp_due.push_back(want);
      end
      if (rsp_valid && !rsp_stall) begin
        if (rsp_due.size() == 0) begin
          if (errors < 10)
            $display("word %0d: response with nothing expected (%h)", rsp_seen, rsp);
          errors++;
        end else begin
          want = rsp_due.pop_front();
          if (rsp !== want) begin
            // read_data/out_level/irq_rise
            if (errors < 10)
              $display("word %0d: exp %h/%b/%b got %h/%b/%b", rsp_seen,
                       want.read_data, want.out_level, want.irq_rise,
                       rsp.read_data, rsp.out_level, rsp.irq_rise);
            errors++;
          end
        end
        rsp_seen++;
      end
    end
    owed = rsp_due.size();
  end

endmodule

>>> bench/interval_timer_channel_tb.sv
module interval_timer_channel_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import itc_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [1:0] PORT_ONE  = 2'd1;
  localparam logic [1:0] PORT_TWO  = 2'd2;
  localparam logic [1:0] ACCESS_LO = 2'b01;
  localparam logic [1:0] ACCESS_HI = 2'b10;
  localparam logic [1:0] CHAN_LAST = 2'b11;

  localparam int RANDOM_WORDS = 2000;
  localparam int QUIET_WORDS  = 200;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 400000;

  logic     clk = 1'b0;
  logic     rst;
  logic     req_valid;
  logic     req_stall;
  itc_req_t req;
  logic     rsp_valid;
  logic     rsp_stall;
  itc_rsp_t rsp;

  int errors;
  int owed;
  int sent;
  int cycles;
  bit quiet;
  bit hold_off;

  interval_timer_channel u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  interval_timer_channel_chk u_chk (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .errors   (errors),
    .owed     (owed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("interval_timer_channel_tb NOT OK");
      $finish;
    end
  end

  // response side: random stall bursts, long hold-offs on request
  initial begin
    rsp_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end else begin
        rsp_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  function automatic logic [7:0] cmd_byte(logic [1:0] chan, logic [1:0] acc, logic [3:0] rest);
    return {chan, acc, rest};
  endfunction

  // offer one word at the falling edge, hold it until taken
  task automatic put(input logic [1:0] k, input logic [1:0] p, input logic [7:0] d);
    itc_req_t w;
    w.kind = k;
    w.port = p;
    w.write_data = d;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    req <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic load_period(input logic [15:0] per);
    put(KIND_WRITE, PORT_CMD, cmd_byte(CHAN_ZERO, ACCESS_LOHI, 4'($urandom_range(0, 15))));
    put(KIND_WRITE, PORT_DATA, per[7:0]);
    put(KIND_WRITE, PORT_DATA, per[15:8]);
  endtask

  // mostly short periods so that the wave turns over often
  function automatic logic [15:0] pick_period();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'($urandom_range(1, 40));
    if (r == 7) return 16'h0000;
    if (r == 8) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin
    int          stop_at;
    int          next_load;
    int          holds;
    int unsigned r;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    quiet = 1'b0;
    hold_off = 1'b0;
    sent = 0;
    holds = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part
    put(KIND_READ, PORT_DATA, 8'h00);
    put(KIND_TICK, PORT_CMD, 8'hFF);           // tick while stopped
    put(KIND_NONE, PORT_DATA, 8'h00);
    put(KIND_WRITE, PORT_ONE, 8'hA5);
    put(KIND_READ, PORT_CMD, 8'h00);
    put(KIND_READ, PORT_TWO, 8'h5A);
    put(KIND_WRITE, PORT_CMD, cmd_byte(CHAN_ZERO, ACCESS_LOHI, 4'hF));
    put(KIND_WRITE, PORT_DATA, 8'h03);
    put(KIND_WRITE, PORT_DATA, 8'h00);
    repeat (3) put(KIND_TICK, PORT_DATA, 8'h00);
    put(KIND_WRITE, PORT_CMD, cmd_byte(CHAN_ZERO, ACCESS_LATCH, 4'h0));
    put(KIND_TICK, PORT_DATA, 8'h00);
    put(KIND_WRITE, PORT_CMD, cmd_byte(CHAN_ZERO, ACCESS_LATCH, 4'h6));  // latch already held
    put(KIND_READ, PORT_DATA, 8'h00);
    put(KIND_READ, PORT_DATA, 8'h00);
    put(KIND_WRITE, PORT_CMD, cmd_byte(CHAN_LAST, ACCESS_LOHI, 4'h6));
    put(KIND_WRITE, PORT_CMD, cmd_byte(CHAN_ZERO, ACCESS_LO, 4'h6));
    put(KIND_WRITE, PORT_CMD, cmd_byte(CHAN_ZERO, ACCESS_HI, 4'h6));
    put(KIND_WRITE, PORT_DATA, 8'hFF);         // data with no fresh command
    put(KIND_WRITE, PORT_DATA, 8'hFF);
    put(KIND_TICK, PORT_DATA, 8'h00);
    put(KIND_WRITE, PORT_DATA, 8'h00);         // period 65536
    put(KIND_WRITE, PORT_DATA, 8'h00);
    put(KIND_TICK, PORT_DATA, 8'h00);
    load_period(16'd1);
    repeat (2) put(KIND_TICK, PORT_DATA, 8'h00);

    // random part
    stop_at = sent + RANDOM_WORDS;
    next_load = sent;
    while (sent < stop_at) begin
      if ((holds == 0 && sent >= stop_at - 1500) || (holds == 1 && sent >= stop_at - 700)) begin
        hold_off = 1'b1;
        holds++;
      end
      quiet = (sent >= stop_at - QUIET_WORDS);
      if (sent >= next_load) begin
        load_period(pick_period());
        next_load = sent + $urandom_range(20, 150);
      end
      r = $urandom_range(0, 19);
      if (r <= 10)
        put(KIND_TICK, PORT_DATA, 8'($urandom_range(0, 255)));
      else if (r <= 12)
        put(KIND_READ, PORT_DATA, 8'($urandom_range(0, 255)));
      else if (r == 13)
        put(KIND_WRITE, PORT_CMD, cmd_byte(CHAN_ZERO, ACCESS_LATCH, 4'($urandom_range(0, 15))));
      else if (r == 14)
        put(KIND_WRITE, PORT_DATA, 8'($urandom_range(0, 255)));
      else
        put(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end

    req_valid <= 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("interval_timer_channel_tb OK");
    else
      $display("interval_timer_channel_tb NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/itc_pkg.sv
rtl/core/itc_level.sv
rtl/core/interval_timer_channel.sv
rtl/core/itc_checker.sv
bench/interval_timer_channel_chk.sv
bench/interval_timer_channel_tb.sv
